// ----- rtl/afl_pkg.sv -----
package afl_pkg;

  localparam int OUT_W       = 22;
  localparam int NUM_AXES    = 3;
  localparam int COEF_W      = 15;
  localparam int HALF_TAPS   = 11;
  localparam int STAGES      = 4;
  localparam int ROUND_SHIFT = 14;
  localparam int OUT_MAX     = 2097151;
  localparam int OUT_MIN     = -2097152;

  typedef logic signed [OUT_W-1:0] val_t;
  typedef logic [COEF_W-1:0]       coef_t;

  // Q0.18 half of the symmetric low-pass, outer tap first, centre last
  localparam coef_t COEF_HALF [HALF_TAPS] = '{
    15'd8607,  15'd8677,  15'd10029, 15'd11320, 15'd12781, 15'd13330,
    15'd13464, 15'd13946, 15'd15278, 15'd15612, 15'd16039
  };

  // per-item control travelling alongside the datapath
  typedef struct packed {
    logic valid;
    logic start;
    logic keep;
    logic last;
  } flag_t;

  typedef struct packed {
    logic              accept;
    logic              start;
    logic [STAGES-1:0] en;
  } lane_ctl_t;

  function automatic coef_t tap_coef(input int idx);
    int i;
    i = idx;
    if (i < 0) i = 0;
    if (i > HALF_TAPS - 1) i = HALF_TAPS - 1;
    return COEF_HALF[i];
  endfunction

endpackage

// ----- rtl/accel_fir_lowpass_anchor.sv -----
// Three-axis accelerometer low-pass with anchor boost.
// Input channel: in_valid/in_ready transfer one sample per axis plus the
// in_record_start and in_record_last marks. Result channel: out_valid/out_ready
// transfer out_out_x/y/z (22-bit signed, 1/16 sample units, saturated) and
// out_end_of_record.
// The first TAP_COUNT samples of a recording give no result; the first kept
// value per axis becomes the anchor and each result is 2*filtered - anchor.
// Throughput: one sample per clock while the result channel is not stalled;
// each axis has its own filter lane. out_valid rises once the item has passed
// the window, pair-product, sum and rounding registers and the boost/output register.
// Each stage holds its item only while the stage after it is occupied and
// stalled, so bubbles are squeezed out; in_ready falls only when every stage
// and the output register hold items and out_ready is low.
// Reset clears history, sample count, anchor state and all valid flags; the
// next sample then continues a recording from zero history, as if it carried
// a start mark.
module accel_fir_lowpass_anchor #(
  parameter int TAP_COUNT   = 21,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_record_start,
  input  logic                          in_record_last,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output afl_pkg::val_t                 out_out_x,
  output afl_pkg::val_t                 out_out_y,
  output afl_pkg::val_t                 out_out_z,
  output logic                          out_end_of_record
);
  import afl_pkg::*;

  localparam int CNT_W = $clog2(TAP_COUNT + 1);

  logic [CNT_W-1:0]              cnt_r;
  logic [CNT_W-1:0]              cnt_nxt;
  logic [CNT_W-1:0]              cnt_base;
  logic                          keep_in;
  logic                          accept;
  flag_t                         flag_r [STAGES];
  logic [STAGES-1:0]             en;
  logic [STAGES-1:0]             stg_valid;
  logic                          mrg_ready;
  lane_ctl_t                     ctl;
  logic signed [SAMPLE_BITS-1:0] samp [NUM_AXES];
  val_t                          filt [NUM_AXES];
  val_t                          res  [NUM_AXES];

  assign samp[0] = in_accel_x;
  assign samp[1] = in_accel_y;
  assign samp[2] = in_accel_z;

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    en[STAGES-1] = !flag_r[STAGES-1].valid || mrg_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !flag_r[i].valid || en[i+1];
    end
    for (int i = 0; i < STAGES; i++) stg_valid[i] = flag_r[i].valid;
  end

  assign in_ready = en[0];
  assign accept   = in_valid && in_ready;

  // warm-up count, saturating once results start
  always_comb begin
    cnt_base = in_record_start ? '0 : cnt_r;
    keep_in  = (cnt_base == CNT_W'(TAP_COUNT));
    cnt_nxt  = keep_in ? cnt_base : cnt_base + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < STAGES; i++) flag_r[i] <= '0;
    end else begin
      if (accept) cnt_r <= cnt_nxt;
      if (en[0]) begin
        flag_r[0] <= '{valid: in_valid, start: in_record_start,
                       keep: keep_in, last: in_record_last};
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) flag_r[i] <= flag_r[i-1];
      end
    end
  end

  assign ctl = '{accept: accept, start: in_record_start, en: en};

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    afl_lane #(
      .TAP_COUNT  (TAP_COUNT),
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sample(samp[a]),
      .filt  (filt[a])
    );
  end

  afl_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (flag_r[STAGES-1]),
    .filt     (filt),
    .out_ready(out_ready),
    .ready    (mrg_ready),
    .out_valid(out_valid),
    .out_val  (res),
    .out_last (out_end_of_record)
  );

  assign out_out_x = res[0];
  assign out_out_y = res[1];
  assign out_out_z = res[2];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TAP_COUNT))
    else $error("sample count past tap count");

  a_start_discarded: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r[0].valid && flag_r[0].start |-> !flag_r[0].keep)
    else $error("start sample marked as kept");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && (&stg_valid) |-> !in_ready)
    else $error("input taken with pipeline full and stalled");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r[STAGES-1].valid && !mrg_ready |=> flag_r[STAGES-1].valid)
    else $error("last stage item lost while output stalled");

endmodule

// ----- rtl/afl_lane.sv -----
module afl_lane #(
  parameter int TAP_COUNT   = 21,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  afl_pkg::lane_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output afl_pkg::val_t                 filt
);
  import afl_pkg::*;

  localparam int NPAIR   = (TAP_COUNT + 1) / 2;
  localparam int PAIR_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = PAIR_W + COEF_W + 1;
  localparam int ACC_W   = PROD_W + $clog2(NPAIR);
  localparam int ROUND_W = ACC_W - ROUND_SHIFT;
  localparam int FW      = (ROUND_W > OUT_W + 1) ? ROUND_W : OUT_W + 1;
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(2 ** (ROUND_SHIFT - 1));
  localparam logic signed [FW-1:0]    F_MAX    = FW'(OUT_MAX);
  localparam logic signed [FW-1:0]    F_MIN    = FW'(OUT_MIN);

  logic signed [SAMPLE_BITS-1:0] hist_r   [TAP_COUNT-1];
  logic signed [SAMPLE_BITS-1:0] wnd_r    [TAP_COUNT];
  logic signed [SAMPLE_BITS-1:0] wnd_nxt  [TAP_COUNT];
  logic signed [PROD_W-1:0]      prod_r   [NPAIR];
  logic signed [PROD_W-1:0]      prod_nxt [NPAIR];
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ROUND_W-1:0]     quo;
  logic signed [FW-1:0]          ext;
  val_t                          filt_r;
  val_t                          filt_nxt;

  // tap window: the new sample plus history, history dropped on a start mark
  always_comb begin
    wnd_nxt[0] = sample;
    for (int k = 1; k < TAP_COUNT; k++) begin
      wnd_nxt[k] = ctl.start ? '0 : hist_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAP_COUNT - 1; k++) hist_r[k] <= '0;
    end else if (ctl.accept) begin
      for (int k = 0; k < TAP_COUNT - 1; k++) hist_r[k] <= wnd_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) wnd_r <= wnd_nxt;
  end

  // fold the symmetric pairs, one constant multiply per pair
  always_comb begin
    logic signed [PAIR_W-1:0] pair;
    for (int i = 0; i < NPAIR; i++) begin
      if (i == TAP_COUNT - 1 - i) begin
        pair = PAIR_W'(wnd_r[i]);
      end else begin
        pair = PAIR_W'(wnd_r[i]) + PAIR_W'(wnd_r[TAP_COUNT-1-i]);
      end
      prod_nxt[i] = PROD_W'(pair) * PROD_W'($signed({1'b0, tap_coef(i)}));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) prod_r <= prod_nxt;
  end

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < NPAIR; i++) acc_nxt = acc_nxt + ACC_W'(prod_r[i]);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) acc_r <= acc_nxt;
  end

  // round half up to 1/16 sample, then clamp to the output range
  always_comb begin
    rnd = acc_r + HALF_LSB;
    quo = rnd[ACC_W-1:ROUND_SHIFT];
    ext = FW'(quo);
    if (ext > F_MAX)      filt_nxt = val_t'(OUT_MAX);
    else if (ext < F_MIN) filt_nxt = val_t'(OUT_MIN);
    else                  filt_nxt = ext[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) filt_r <= filt_nxt;
  end

  assign filt = filt_r;

endmodule

// ----- rtl/afl_merge.sv -----
module afl_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  afl_pkg::flag_t  item,
  input  afl_pkg::val_t   filt [afl_pkg::NUM_AXES],
  input  logic            out_ready,
  output logic            ready,
  output logic            out_valid,
  output afl_pkg::val_t   out_val [afl_pkg::NUM_AXES],
  output logic            out_last
);
  import afl_pkg::*;

  localparam int BW = OUT_W + 2;
  localparam logic signed [BW-1:0] B_MAX = BW'(OUT_MAX);
  localparam logic signed [BW-1:0] B_MIN = BW'(OUT_MIN);

  logic  out_valid_r;
  logic  anchor_valid_r;
  logic  out_last_r;
  val_t  anchor_r  [NUM_AXES];
  val_t  out_val_r [NUM_AXES];
  val_t  out_nxt   [NUM_AXES];
  logic  load;

  assign ready = !out_valid_r || out_ready;
  assign load  = ready && item.valid && item.keep;

  // the first kept value is its own anchor, so it passes through unchanged
  always_comb begin
    val_t              base;
    logic signed [BW-1:0] boost;
    for (int a = 0; a < NUM_AXES; a++) begin
      base  = anchor_valid_r ? anchor_r[a] : filt[a];
      boost = (BW'(filt[a]) <<< 1) - BW'(base);
      if (boost > B_MAX)      out_nxt[a] = val_t'(OUT_MAX);
      else if (boost < B_MIN) out_nxt[a] = val_t'(OUT_MIN);
      else                    out_nxt[a] = boost[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      anchor_valid_r <= 1'b0;
    end else begin
      if (ready) out_valid_r <= item.valid && item.keep;
      if (ready && item.valid && item.start) anchor_valid_r <= 1'b0;
      else if (load)                         anchor_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_val_r  <= out_nxt;
      out_last_r <= item.last;
      if (!anchor_valid_r) anchor_r <= filt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_val   = out_val_r;
  assign out_last  = out_last_r;

endmodule
